// File: hdl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared widths and codes for the linear-probing hash table unit.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int KEY_W     = 63;
  localparam int HASH_W    = 32;
  localparam int VAL_W     = 64;
  localparam int COUNT_W   = 4;
  // key slot word: valid flag on top of the key
  localparam int KSLOT_W   = KEY_W + 1;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

// File: hdl/linear_probe_hash_table_unit.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Open-addressing hash table with linear probing, keys and values in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive operation/key/key_hash/value_in and raise start;
//   the command transfers on a clock edge where start is high and busy low.
//   Result channel: done is high for exactly one cycle with found, value_out,
//   status and entries_used; the receiver must take it in that cycle.
// Sequence:
//   The start slot (key_hash mod CAPACITY) passes the hash, quotient and
//   remainder registers of the pipelined reciprocal reducer, then slots are
//   probed in turn through the key/value RAM read port (p = 1 .. CAPACITY
//   probes). done is registered from the last probe; busy drops in that
//   same edge, so the next command may transfer as the result cycle ends.
// Reset:
//   rst (synchronous) starts a clearing pass that zeroes the slot valid
//   flags in the key RAM, one slot per cycle, with busy high throughout.
//   Value RAM contents are not cleared.
// Stall:
//   The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit import lpht_pkg::*; #(
  parameter int CAPACITY = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               operation,
  input  logic [KEY_W-1:0]   key,
  input  logic [HASH_W-1:0]  key_hash,
  input  logic [VAL_W-1:0]   value_in,
  output logic               done,
  output logic               found,
  output logic [VAL_W-1:0]   value_out,
  output logic               status,
  output logic [COUNT_W-1:0] entries_used
);

  localparam int IW = $clog2(CAPACITY);
  localparam int UW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_HASH  = 2'd2;
  localparam logic [1:0] ST_PROBE = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [IW-1:0]     idx;
  logic [IW-1:0]     idx_adv;
  logic [IW-1:0]     pcnt;
  logic [UW-1:0]     used_count;
  logic [UW-1:0]     used_next;
  logic [UW+COUNT_W-1:0] used_ext;

  logic              op_r;
  logic [KEY_W-1:0]  key_r;
  logic [VAL_W-1:0]  val_r;

  logic              accept;
  logic              mod_done;
  logic [IW-1:0]     mod_rem;

  logic              kram_we;
  logic [IW-1:0]     kram_waddr;
  logic [KSLOT_W-1:0] kram_wdata;
  logic              vram_we;
  logic [IW-1:0]     raddr;
  logic [KSLOT_W-1:0] kdata;
  logic [VAL_W-1:0]  vdata;

  logic              hit;
  logic              empty;
  logic              stop;
  logic              finish;
  logic              claim;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  lpht_hmod #(.CAPACITY(CAPACITY), .IW(IW)) u_hmod (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .hash  (key_hash),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  lpht_ram #(.WIDTH(KSLOT_W), .DEPTH(CAPACITY), .AW(IW)) u_key_ram (
    .clk   (clk),
    .we    (kram_we),
    .waddr (kram_waddr),
    .wdata (kram_wdata),
    .raddr (raddr),
    .rdata (kdata)
  );

  lpht_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY), .AW(IW)) u_val_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (idx),
    .wdata (val_r),
    .raddr (raddr),
    .rdata (vdata)
  );

  // probe decision on the slot read last cycle (address idx)
  assign hit    = kdata[KSLOT_W-1] && (kdata[KEY_W-1:0] == key_r);
  assign empty  = !kdata[KSLOT_W-1];
  assign stop   = hit || empty;
  assign finish = (state == ST_PROBE) && (stop || (pcnt == LAST_IDX));
  assign claim  = finish && (op_r == OP_SET) && empty;

  assign idx_adv = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  // next slot (idx + 1, wrapping) is fetched speculatively while slot idx is decided
  assign raddr   = (state == ST_HASH) ? mod_rem : idx_adv;

  always_comb begin
    kram_we    = 1'b0;
    kram_waddr = idx;
    kram_wdata = {1'b1, key_r};
    vram_we    = 1'b0;
    if (state == ST_CLEAR) begin
      kram_we    = 1'b1;
      kram_wdata = '0;
    end else if (finish && (op_r == OP_SET) && stop) begin
      kram_we = 1'b1;
      vram_we = 1'b1;
    end
  end

  always_comb begin
    used_next = used_count;
    if (claim && (used_count < UW'(CAPACITY))) begin
      used_next = used_count + 1'b1;
    end
  end
  assign used_ext = {{COUNT_W{1'b0}}, used_next};

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (idx == LAST_IDX) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_HASH;
      ST_HASH:  if (mod_done) state_next = ST_PROBE;
      ST_PROBE: if (finish) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      idx        <= '0;
      pcnt       <= '0;
      used_count <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      used_count <= used_next;
      done       <= finish;
      case (state)
        ST_CLEAR: idx <= idx_adv;
        ST_HASH: begin
          idx  <= mod_rem;
          pcnt <= '0;
        end
        ST_PROBE: begin
          if (!finish) begin
            idx  <= idx_adv;
            pcnt <= pcnt + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= operation;
      key_r <= key;
      val_r <= value_in;
    end
    if (finish) begin
      found        <= hit;
      value_out    <= ((op_r == OP_GET) && hit) ? vdata : '0;
      status       <= ((op_r == OP_SET) && !stop) ? STATUS_FULL : STATUS_OK;
      entries_used <= used_ext[COUNT_W-1:0];
    end
  end

`ifndef NO_ASSERTIONS
  a_done_after_probe: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_PROBE))
    else $error("result strobe without a probe");

  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    done |-> !(status && found))
    else $error("full status together with found");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= UW'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after command transfer");
`endif

endmodule

// File: hdl/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/lpht_hmod.sv
// ----------------------------------------------------------------------------
// lpht_hmod
// Hash modulo capacity by reciprocal multiplication, pipelined through the
// hash, quotient and remainder registers; done pulses with the remainder.
// ----------------------------------------------------------------------------
module lpht_hmod import lpht_pkg::*; #(
  parameter int CAPACITY = 8,
  parameter int IW       = $clog2(CAPACITY)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [HASH_W-1:0] hash,
  output logic              done,
  output logic [IW-1:0]     rem
);

  // MAGIC = ceil(2^(HASH_W+IW) / CAPACITY); the quotient is exact for any hash
  localparam logic [63:0]     SCALE   = 64'd1 << (HASH_W + IW);
  localparam logic [63:0]     MAGIC64 = (SCALE + 64'(CAPACITY) - 64'd1) / 64'(CAPACITY);
  localparam logic [HASH_W:0] MAGIC   = MAGIC64[HASH_W:0];
  localparam logic [IW-1:0]   CAP_LO  = IW'(CAPACITY);

  logic [HASH_W-1:0] h_r;
  logic [IW-1:0]     h_lo;
  logic [IW-1:0]     q_lo;
  logic [IW-1:0]     qd_lo;
  logic [2*HASH_W:0] prod;
  logic              v1;
  logic              v2;
  logic [IW-1:0]     r;

  assign prod  = {{(HASH_W+1){1'b0}}, h_r} * {{HASH_W{1'b0}}, MAGIC};
  // remainder is below 2^IW, so only the low IW bits of q * CAPACITY matter
  assign qd_lo = q_lo * CAP_LO;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      h_r <= hash;
    end
    if (v1) begin
      q_lo <= prod[HASH_W+IW +: IW];
      h_lo <= h_r[IW-1:0];
    end
    if (v2) begin
      r <= h_lo - qd_lo;
    end
  end

  assign rem = r;

endmodule
